// ===== design/dtlp_pkg.sv =====
// Package for the date-time line parser: word types, character codes, field selects.
`timescale 1ns / 1ps

package dtlp_pkg;

  // Default line buffer size in bytes; a line closes at one less than this
  localparam int LINE_BUFFER_BYTES_DEF = 32;

  // Exact length of a "YYYY-MM-DD HH:MM:SS" line
  localparam int DT_LENGTH = 19;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Range limits
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RXERR = 2'd2;

  // Which field a character position feeds
  typedef enum logic [2:0] {
    FLD_NONE,
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND
  } fld_t;

  // Classification of one character at its line position
  typedef struct packed {
    fld_t       fld;
    logic       fmt_ok;
    logic [3:0] digit;
  } char_class_t;

  // Input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } out_word_t;

  // Decimal shift-in: v * 10 + d, kept to 14 bits
  function automatic logic [13:0] acc10(input logic [13:0] v, input logic [3:0] d);
    acc10 = (v << 3) + (v << 1) + {10'd0, d};
  endfunction

endpackage

// ===== design/dtlp_char_class.sv =====
// Character classifier: checks one byte against the pattern at its line position.
`timescale 1ns / 1ps

module dtlp_char_class
  import dtlp_pkg::*;
#(
  parameter int POS_W = 5
) (
  input  logic [POS_W-1:0] pos,
  input  logic [7:0]       ch,
  output char_class_t      cls
);

  logic       is_digit;
  logic [7:0] ch_off;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign ch_off   = ch - CH_ZERO;

  // Separator or digit expected at each position; past the end nothing fits
  always_comb begin
    cls.fld    = FLD_NONE;
    cls.fmt_ok = 1'b0;
    cls.digit  = is_digit ? ch_off[3:0] : 4'd0;
    if (pos == POS_W'(4) || pos == POS_W'(7)) begin
      cls.fmt_ok = (ch == CH_DASH);
    end else if (pos == POS_W'(10)) begin
      cls.fmt_ok = (ch == CH_SPACE);
    end else if (pos == POS_W'(13) || pos == POS_W'(16)) begin
      cls.fmt_ok = (ch == CH_COLON);
    end else if (pos < POS_W'(DT_LENGTH)) begin
      cls.fmt_ok = is_digit;
      if (is_digit) begin
        if (pos <= POS_W'(3)) begin
          cls.fld = FLD_YEAR;
        end else if (pos <= POS_W'(6)) begin
          cls.fld = FLD_MONTH;
        end else if (pos <= POS_W'(9)) begin
          cls.fld = FLD_DAY;
        end else if (pos <= POS_W'(12)) begin
          cls.fld = FLD_HOUR;
        end else if (pos <= POS_W'(15)) begin
          cls.fld = FLD_MINUTE;
        end else begin
          cls.fld = FLD_SECOND;
        end
      end
    end
  end

endmodule

// ===== design/dtlp_line_state.sv =====
// Line state: position, pattern flag and field accumulators; forms the result word.
`timescale 1ns / 1ps

module dtlp_line_state
  import dtlp_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  in_word_t  in_w,
  output logic      emit,
  output out_word_t res
);

  localparam int POS_W = $clog2(LINE_BUFFER_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_after;
  logic             good_r, good_nxt, good_after;
  logic [13:0]      year_r, year_nxt, year_after;
  logic [6:0]       month_r, month_nxt, month_after;
  logic [6:0]       day_r, day_nxt, day_after;
  logic [6:0]       hour_r, hour_nxt, hour_after;
  logic [6:0]       minute_r, minute_nxt, minute_after;
  logic [6:0]       second_r, second_nxt, second_after;

  char_class_t cls;
  logic        is_eol;
  logic        finish;
  logic        ok;

  dtlp_char_class #(.POS_W(POS_W)) u_class (
    .pos (pos_r),
    .ch  (in_w.rx_byte),
    .cls (cls)
  );

  assign is_eol = (in_w.rx_byte == CH_CR) || (in_w.rx_byte == CH_LF);

  // State after taking the byte as a character (unchanged on end of line)
  always_comb begin
    pos_after    = pos_r;
    good_after   = good_r;
    year_after   = year_r;
    month_after  = month_r;
    day_after    = day_r;
    hour_after   = hour_r;
    minute_after = minute_r;
    second_after = second_r;
    if (!is_eol) begin
      pos_after  = pos_r + POS_W'(1);
      good_after = good_r & cls.fmt_ok;
      case (cls.fld)
        FLD_YEAR:   year_after   = acc10(year_r, cls.digit);
        FLD_MONTH:  month_after  = 7'(acc10({7'd0, month_r}, cls.digit));
        FLD_DAY:    day_after    = 7'(acc10({7'd0, day_r}, cls.digit));
        FLD_HOUR:   hour_after   = 7'(acc10({7'd0, hour_r}, cls.digit));
        FLD_MINUTE: minute_after = 7'(acc10({7'd0, minute_r}, cls.digit));
        FLD_SECOND: second_after = 7'(acc10({7'd0, second_r}, cls.digit));
        default:    ;
      endcase
    end
  end

  // Line closes on CR/LF after a character, or when the buffer fills
  always_comb begin
    if (in_w.rx_error) begin
      finish = 1'b0;
    end else if (is_eol) begin
      finish = (pos_r != '0);
    end else begin
      finish = (pos_after == POS_W'(LINE_BUFFER_BYTES - 1));
    end
  end

  assign ok = good_after && (pos_after == POS_W'(DT_LENGTH)) &&
              (month_after >= 7'd1) && (month_after <= MONTH_MAX) &&
              (day_after >= 7'd1) && (day_after <= DAY_MAX) &&
              (hour_after <= HOUR_MAX) && (minute_after <= MINSEC_MAX) &&
              (second_after <= MINSEC_MAX);

  assign emit = take && (in_w.rx_error || finish);

  // Result word; fields only on a good parse
  always_comb begin
    res = '0;
    if (in_w.rx_error) begin
      res.status = ST_RXERR;
    end else if (ok) begin
      res.status = ST_OK;
      res.year   = year_after;
      res.month  = month_after[3:0];
      res.day    = day_after[4:0];
      res.hour   = hour_after[4:0];
      res.minute = minute_after[5:0];
      res.second = second_after[5:0];
    end else begin
      res.status = ST_BAD;
    end
  end

  // Next state: clear after any result, otherwise keep what the byte left
  always_comb begin
    pos_nxt    = pos_r;
    good_nxt   = good_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    if (take) begin
      if (in_w.rx_error || finish) begin
        pos_nxt    = '0;
        good_nxt   = 1'b1;
        year_nxt   = '0;
        month_nxt  = '0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
        second_nxt = '0;
      end else begin
        pos_nxt    = pos_after;
        good_nxt   = good_after;
        year_nxt   = year_after;
        month_nxt  = month_after;
        day_nxt    = day_after;
        hour_nxt   = hour_after;
        minute_nxt = minute_after;
        second_nxt = second_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      good_r   <= 1'b1;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      good_r   <= good_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== design/datetime_line_parser.sv =====
// A result word is registered and presented in the cycle after the byte that closes its line.
// Throughput: one byte per cycle while in_ready is high; the byte path is one short decode and a x10 shift-add.
// The input stays ready while the result register is empty or being taken this cycle.
// Reset (rst_n low, synchronous) empties the line state and drops any pending result.
// Top level of the date-time line parser; holds the result register and handshakes.
`timescale 1ns / 1ps

module datetime_line_parser
  import dtlp_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      take;
  logic      emit;
  out_word_t res;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  dtlp_line_state #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)) u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .in_w  (in_word),
    .emit  (emit),
    .res   (res)
  );

  // Result register: loads a new word whenever one is produced
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== test/dtlp_checker.sv =====
// Checker for the date-time line parser: watches both channels, predicts and compares words.
`timescale 1ns / 1ps

module dtlp_checker
  import dtlp_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BUFFER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);

  // Predicted line state
  int          chars_taken;
  logic        pattern_ok;
  logic [13:0] yr_acc;
  logic [6:0]  mon_acc;
  logic [6:0]  day_acc;
  logic [6:0]  hr_acc;
  logic [6:0]  min_acc;
  logic [6:0]  sec_acc;

  // Result words still to come, oldest first
  out_word_t   expected_q[$];

  task automatic clear_line();
    chars_taken = 0;
    pattern_ok  = 1'b1;
    yr_acc      = '0;
    mon_acc     = '0;
    day_acc     = '0;
    hr_acc      = '0;
    min_acc     = '0;
    sec_acc     = '0;
  endtask

  // Line closed: range-check the fields and queue the status word
  task automatic close_line();
    out_word_t w;
    w = '0;
    if (pattern_ok && chars_taken == DT_LENGTH &&
        mon_acc >= 7'd1 && mon_acc <= MONTH_MAX &&
        day_acc >= 7'd1 && day_acc <= DAY_MAX &&
        hr_acc <= HOUR_MAX && min_acc <= MINSEC_MAX && sec_acc <= MINSEC_MAX) begin
      w.status = ST_OK;
      w.year   = yr_acc;
      w.month  = mon_acc[3:0];
      w.day    = day_acc[4:0];
      w.hour   = hr_acc[4:0];
      w.minute = min_acc[5:0];
      w.second = sec_acc[5:0];
    end else begin
      w.status = ST_BAD;
    end
    expected_q.push_back(w);
    clear_line();
  endtask

  // Check one character against the pattern at its position, shift digits in
  task automatic take_char(input logic [7:0] ch);
    logic       is_dig;
    logic [3:0] d;
    is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    d      = is_dig ? 4'(ch - CH_ZERO) : 4'd0;
    case (chars_taken)
      4, 7:    if (ch != CH_DASH) pattern_ok = 1'b0;
      10:      if (ch != CH_SPACE) pattern_ok = 1'b0;
      13, 16:  if (ch != CH_COLON) pattern_ok = 1'b0;
      default: begin
        if (chars_taken >= DT_LENGTH || !is_dig) pattern_ok = 1'b0;
        else if (chars_taken <= 3)  yr_acc  = 14'(yr_acc * 10 + d);
        else if (chars_taken <= 6)  mon_acc = 7'(mon_acc * 10 + d);
        else if (chars_taken <= 9)  day_acc = 7'(day_acc * 10 + d);
        else if (chars_taken <= 12) hr_acc  = 7'(hr_acc * 10 + d);
        else if (chars_taken <= 15) min_acc = 7'(min_acc * 10 + d);
        else                        sec_acc = 7'(sec_acc * 10 + d);
      end
    endcase
  endtask

  // One accepted input word
  task automatic predict_word(input in_word_t w);
    out_word_t err_word;
    err_word = '0;
    if (w.rx_error) begin
      // receive failure aborts the line whatever the byte holds
      err_word.status = ST_RXERR;
      expected_q.push_back(err_word);
      clear_line();
    end else if (w.rx_byte == CH_CR || w.rx_byte == CH_LF) begin
      if (chars_taken != 0) close_line();
    end else begin
      take_char(w.rx_byte);
      chars_taken++;
      if (chars_taken + 1 >= LINE_BYTES) close_line();
    end
  endtask

  task automatic check_field(input string nm, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", nm, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare the taken result word first: it was caused by an earlier input word
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_line();
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing pending: status %0d", out_word.status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, out_word.status);
          check_field("year",   want.year,   out_word.year);
          check_field("month",  want.month,  out_word.month);
          check_field("day",    want.day,    out_word.day);
          check_field("hour",   want.hour,   out_word.hour);
          check_field("minute", want.minute, out_word.minute);
          check_field("second", want.second, out_word.second);
        end
      end
      if (in_valid && in_ready) predict_word(in_word);
    end
    pending = expected_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the date-time line parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import dtlp_pkg::*;

  localparam int LINE_BYTES   = LINE_BUFFER_BYTES_DEF;
  localparam int RANDOM_BYTES = 1120;
  localparam int MAX_GAP      = 14;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int         fail_count;
  int         pending;
  int         bytes_sent;
  bit         calm_in;
  bit         calm_out;
  logic [7:0] line_buf[$];

  datetime_line_parser #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  dtlp_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one word; starts and ends at a falling edge
  task automatic push_item(input logic [7:0] ch, input logic err);
    int       gap;
    in_word_t w;
    gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.rx_byte  = ch;
    w.rx_error = err;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) push_item(line_buf[i], 1'b0);
    line_buf.delete();
  endtask

  task automatic put_num(input int v, input int n);
    int div;
    int i;
    div = 1;
    for (i = 1; i < n; i++) div = div * 10;
    for (i = 0; i < n; i++) begin
      line_buf.push_back(CH_ZERO + 8'((v / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic put_dt(input int y, input int mo, input int d,
                        input int h, input int mi, input int s);
    put_num(y, 4);
    line_buf.push_back(CH_DASH);
    put_num(mo, 2);
    line_buf.push_back(CH_DASH);
    put_num(d, 2);
    line_buf.push_back(CH_SPACE);
    put_num(h, 2);
    line_buf.push_back(CH_COLON);
    put_num(mi, 2);
    line_buf.push_back(CH_COLON);
    put_num(s, 2);
  endtask

  // Mostly in range, now and then any two-digit value
  function automatic int rnd_field(input int lo, input int hi);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
  endfunction

  function automatic logic [7:0] rnd_plain();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == CH_CR || ch == CH_LF);
    return ch;
  endfunction

  task automatic put_random_dt();
    put_dt($urandom_range(0, 9999), rnd_field(1, 12), rnd_field(1, 31),
           rnd_field(0, 23), rnd_field(0, 59), rnd_field(0, 59));
  endtask

  task automatic put_end();
    line_buf.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic pad_to(input int n);
    while (line_buf.size() < n) line_buf.push_back(rnd_plain());
  endtask

  // Result side: a fresh random stall before every word, except in calm stretches
  initial begin
    int gap;
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) calm_out = ~calm_out;
      gap = calm_out ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int kind;
    int n;
    int start;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes of every field, empty lines, bad lengths, buffer full, errors
    put_dt(9999, 12, 31, 23, 59, 59);
    line_buf.push_back(CH_CR);
    flush_line();
    push_item(CH_LF, 1'b0);
    push_item(CH_CR, 1'b0);
    put_dt(0, 1, 1, 0, 0, 0);
    line_buf.push_back(CH_LF);
    flush_line();
    put_dt(2024, 13, 32, 24, 60, 60);
    line_buf.push_back(CH_CR);
    flush_line();
    put_dt(1999, 0, 0, 0, 0, 0);
    line_buf.push_back(CH_LF);
    flush_line();
    put_num(12, 2);
    line_buf.push_back(CH_LF);
    flush_line();
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_CR);
    flush_line();
    put_dt(2000, 6, 15, 12, 30, 30);
    line_buf.push_back(CH_ZERO);
    line_buf.push_back(CH_LF);
    flush_line();
    pad_to(LINE_BYTES - 2);
    line_buf.push_back(CH_LF);
    flush_line();
    put_dt(2001, 2, 3, 4, 5, 6);
    pad_to(LINE_BYTES - 1);
    flush_line();
    put_num(20, 2);
    flush_line();
    push_item(8'hFF, 1'b1);
    push_item(CH_CR, 1'b1);

    // random: mostly well-formed lines with random content, the rest noise
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) calm_in = ~calm_in;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        put_random_dt();
        if ($urandom_range(0, 6) == 0)
          line_buf[$urandom_range(0, DT_LENGTH - 1)] = 8'($urandom_range(0, 255));
        put_end();
      end else if (kind < 65) begin
        n = $urandom_range(1, 40);
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        put_end();
      end else if (kind < 72) begin
        n = $urandom_range(1, 3);
        repeat (n) put_end();
      end else if (kind < 82) begin
        // abort part-way through a line
        put_random_dt();
        n = $urandom_range(0, DT_LENGTH);
        while (line_buf.size() > n) void'(line_buf.pop_back());
        flush_line();
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (kind < 91) begin
        put_random_dt();
        if ($urandom_range(0, 1)) begin
          pad_to(LINE_BYTES - 1);
        end else begin
          pad_to(LINE_BYTES - 2);
          put_end();
        end
      end else begin
        put_random_dt();
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1))
          repeat (n) void'(line_buf.pop_back());
        else
          repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        put_end();
      end
      flush_line();
    end

    // drain
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
